@@ rtl/core/smfk_pkg.sv @@
// Shared types and constants for the sync marker frame to KISS block.
// Used by smfk_result_queue and sync_marker_frame_to_kiss; no dependencies.
package smfk_pkg;

  localparam int unsigned MARKER_OCTETS = 4;
  localparam int unsigned GROUP_MAX     = 6;
  localparam int unsigned GROUP_CNT_W   = $clog2(GROUP_MAX + 1);
  localparam int unsigned GROUP_IDX_W   = $clog2(GROUP_MAX);

  localparam logic [7:0] K_FEND  = 8'hC0;
  localparam logic [7:0] K_FESC  = 8'hDB;
  localparam logic [7:0] K_TFEND = 8'hDC;
  localparam logic [7:0] K_TFESC = 8'hDD;

  // configuration register indexes
  localparam logic [1:0] CFG_SYNC_MARKER  = 2'd0;
  localparam logic [1:0] CFG_FRAME_LENGTH = 2'd1;
  localparam logic [1:0] CFG_KISS_COMMAND = 2'd2;

  localparam logic [31:0] SYNC_MARKER_RESET  = 32'h1ACF_FC1D;
  localparam logic [15:0] FRAME_LENGTH_RESET = 16'd260;
  localparam logic [7:0]  KISS_COMMAND_RESET = 8'd0;

  // bytes caused by one input bit, first byte in entry 0
  typedef struct packed {
    logic [GROUP_CNT_W-1:0]          count;
    logic [GROUP_MAX-1:0][7:0]       bytes;
    logic                            close;  // last byte is the closing FEND
  } smfk_group_t;

endpackage

@@ rtl/core/sync_marker_frame_to_kiss.sv @@
// Top level: sync marker search, frame octet packing and KISS escaping.
// Depends on smfk_pkg and smfk_result_queue.

// Takes one received bit per transaction and accepts a new bit every clock
// cycle; each bit is handled in one pass and causes zero to six output bytes
// (a marker hit gives FEND, the command byte and the four marker bytes, a
// completed octet gives one or two escaped bytes plus the closing FEND at
// frame end). Bytes leave one per cycle from a two-group result queue;
// in_ready is low only while both queue slots hold groups, so a stalled or
// slow output side is what throttles the input. A frame whose length is at
// most four octets is closed by the bit after the marker. Configuration
// writes take effect at once; the data length is latched at frame start.
module sync_marker_frame_to_kiss
  import smfk_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        rx_bit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        last,
  output logic        frame_end
);

  logic [31:0] sync_marker;
  logic [15:0] frame_length;
  logic [7:0]  kiss_command;

  logic        receiving;
  logic [31:0] sync_shift;
  logic        inverted;
  logic [2:0]  bit_index;
  logic [7:0]  byte_accum;
  logic [15:0] bytes_left;

  logic        receiving_next;
  logic [31:0] sync_shift_next;
  logic        inverted_next;
  logic [2:0]  bit_index_next;
  logic [7:0]  byte_accum_next;
  logic [15:0] bytes_left_next;

  logic        in_fire;
  logic        can_push;
  smfk_group_t grp;
  logic [31:0] shifted;
  logic        hit_norm;
  logic        hit_inv;
  logic [7:0]  accum_set;
  logic [7:0]  data_byte;
  logic [7:0]  esc0;
  logic [7:0]  esc1;
  logic        esc_two;
  logic        closing;

  assign in_ready = can_push;
  assign in_fire  = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_marker  <= SYNC_MARKER_RESET;
      frame_length <= FRAME_LENGTH_RESET;
      kiss_command <= KISS_COMMAND_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SYNC_MARKER:  sync_marker  <= cfg_data;
        CFG_FRAME_LENGTH: frame_length <= cfg_data[15:0];
        CFG_KISS_COMMAND: kiss_command <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign shifted  = {sync_shift[30:0], rx_bit};
  assign hit_norm = (shifted == sync_marker);
  assign hit_inv  = (shifted == ~sync_marker);

  always_comb begin
    accum_set = byte_accum;
    accum_set[3'd7 - bit_index] = rx_bit;
  end

  assign data_byte = inverted ? ~accum_set : accum_set;
  assign esc_two   = (data_byte == K_FEND) || (data_byte == K_FESC);
  assign esc0      = esc_two ? K_FESC : data_byte;
  assign esc1      = (data_byte == K_FEND) ? K_TFEND : K_TFESC;
  assign closing   = (bytes_left == 16'd1);

  always_comb begin
    receiving_next  = receiving;
    sync_shift_next = sync_shift;
    inverted_next   = inverted;
    bit_index_next  = bit_index;
    byte_accum_next = byte_accum;
    bytes_left_next = bytes_left;
    grp             = '0;
    if (!receiving) begin
      sync_shift_next = shifted;
      if (hit_norm || hit_inv) begin
        receiving_next  = 1'b1;
        inverted_next   = ~hit_norm;
        bit_index_next  = '0;
        byte_accum_next = '0;
        bytes_left_next = (frame_length > 16'(MARKER_OCTETS))
                          ? 16'(frame_length - 16'(MARKER_OCTETS)) : 16'd0;
        grp.count    = GROUP_CNT_W'(GROUP_MAX);
        grp.bytes[0] = K_FEND;
        grp.bytes[1] = kiss_command;
        grp.bytes[2] = sync_marker[31:24];
        grp.bytes[3] = sync_marker[23:16];
        grp.bytes[4] = sync_marker[15:8];
        grp.bytes[5] = sync_marker[7:0];
      end
    end else if (bytes_left == 16'd0) begin
      // empty frame: fill bit only closes it
      receiving_next = 1'b0;
      grp.count      = GROUP_CNT_W'(1);
      grp.bytes[0]   = K_FEND;
      grp.close      = 1'b1;
    end else if (bit_index == 3'd7) begin
      bit_index_next  = '0;
      byte_accum_next = '0;
      bytes_left_next = bytes_left - 16'd1;
      grp.bytes[0]    = esc0;
      grp.bytes[1]    = esc_two ? esc1 : K_FEND;
      grp.bytes[2]    = K_FEND;
      grp.count       = GROUP_CNT_W'({1'b0, esc_two} + 2'd1 + {1'b0, closing});
      grp.close       = closing;
      if (closing) begin
        receiving_next = 1'b0;
      end
    end else begin
      bit_index_next  = bit_index + 3'd1;
      byte_accum_next = accum_set;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      receiving  <= 1'b0;
      sync_shift <= '0;
      inverted   <= 1'b0;
      bit_index  <= '0;
      byte_accum <= '0;
      bytes_left <= '0;
    end else if (in_fire) begin
      receiving  <= receiving_next;
      sync_shift <= sync_shift_next;
      inverted   <= inverted_next;
      bit_index  <= bit_index_next;
      byte_accum <= byte_accum_next;
      bytes_left <= bytes_left_next;
    end
  end

  smfk_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_fire && (grp.count != '0)),
    .push_group (grp),
    .can_push   (can_push),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .last       (last),
    .frame_end  (frame_end)
  );

endmodule

@@ rtl/core/smfk_result_queue.sv @@
// Two-group result queue and byte serializer for the KISS output channel.
// Depends on smfk_pkg.
module smfk_result_queue
  import smfk_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  smfk_group_t push_group,
  output logic        can_push,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        last,
  output logic        frame_end
);

  smfk_group_t            cur;
  smfk_group_t            pend;
  logic                   cur_valid;
  logic                   pend_valid;
  logic [GROUP_IDX_W-1:0] idx;
  logic                   out_fire;
  logic                   cur_free;

  assign can_push  = ~pend_valid;
  assign out_valid = cur_valid;
  assign out_byte  = cur.bytes[idx];
  assign last      = (idx == GROUP_IDX_W'(cur.count - GROUP_CNT_W'(1)));
  assign frame_end = last & cur.close;
  assign out_fire  = out_valid & out_ready;
  // current group slot frees up this cycle or is already empty
  assign cur_free  = ~cur_valid | (out_fire & last);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid  <= 1'b0;
      pend_valid <= 1'b0;
      idx        <= '0;
    end else begin
      if (cur_free) begin
        idx <= '0;
        if (pend_valid) begin
          cur        <= pend;
          cur_valid  <= 1'b1;
          pend_valid <= 1'b0;
        end else if (push) begin
          cur       <= push_group;
          cur_valid <= 1'b1;
        end else begin
          cur_valid <= 1'b0;
        end
      end else begin
        if (out_fire) begin
          idx <= idx + 1'b1;
        end
        if (push) begin
          pend       <= push_group;
          pend_valid <= 1'b1;
        end
      end
    end
  end

endmodule
